/* hw/rtl/assert_macros.svh */
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define RLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("run list decoder: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define RLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("run list decoder: next-cycle check failed");

`endif

/* hw/rtl/rld_pkg.sv */
`default_nettype none

package rld_pkg;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned NIB_W     = 4;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned MAX_BYTES = 8;

   localparam logic [NIB_W-1:0]  NIB_MASK = 4'hF;
   localparam logic [BYTE_W-1:0] SIGN_BIT = 8'h80;

   // Decoder phase while walking the run list
   typedef enum logic [1:0] {
      PH_DONE,
      PH_HEADER,
      PH_LENGTH,
      PH_OFFSET
   } phase_type;

   // What the back end does with a queued command
   typedef enum logic [1:0] {
      OP_NONE,
      OP_RUN,
      OP_STOP
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_RUN,
      ST_END,
      ST_ZERO_LEN,
      ST_TRUNC
   } status_type;

   // One command from the byte parser to the run calculator
   typedef struct packed {
      logic                restart;
      logic [WORD_W-1:0]   start_vcn;
      op_type              op;
      status_type          status;
      logic                last;
      logic [WORD_W-1:0]   length;
      logic [WORD_W-1:0]   offset;
   } entry_type;

   // Command beat with its valid flag
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } beat_type;

endpackage

`default_nettype wire

/* hw/rtl/run_list_decoder.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   data_byte, first_byte, last_byte, start_vcn
// rsp      out        rsp_valid/rsp_stall   run_vcn, run_lcn, run_length, status, is_last
//
// Takes one byte per cycle while req_stall is low; the command a byte causes is registered
// first in the two-entry command queue, then in the output register as a result beat.
// Run arithmetic is one pair of 64-bit adds in the back end, once per command.
// Synchronous reset clears the parser phase, the queue and the output valid.
// req_stall rises only when both queue entries are held by a stalled result side.
`default_nettype none

module run_list_decoder
   import rld_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_first_byte,
   input  wire logic                req_last_byte,
   input  wire logic [WORD_W-1:0]   req_start_vcn,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [WORD_W-1:0]        rsp_run_vcn,
   output logic [WORD_W-1:0]        rsp_run_lcn,
   output logic [WORD_W-1:0]        rsp_run_length,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_is_last
);

   beat_type push;
   beat_type head;
   logic     queue_full;
   logic     pop;

   rld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_start_vcn  (req_start_vcn),
      .queue_full     (queue_full),
      .push           (push)
   );

   rld_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   rld_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_vcn    (rsp_run_vcn),
      .rsp_run_lcn    (rsp_run_lcn),
      .rsp_run_length (rsp_run_length),
      .rsp_status     (rsp_status),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/rld_front.sv */
`default_nettype none

module rld_front
   import rld_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_first_byte,
   input  wire logic              req_last_byte,
   input  wire logic [WORD_W-1:0] req_start_vcn,
   input  wire logic              queue_full,
   output beat_type               push
);

   phase_type         phase_ff, phase_in;
   logic [NIB_W-1:0]  len_left_ff, len_left_in;
   logic [NIB_W-1:0]  off_left_ff, off_left_in;
   logic [NIB_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] len_acc_ff, len_acc_in;
   logic [WORD_W-1:0] off_acc_ff, off_acc_in;

   logic              accept;
   phase_type         ph;
   logic [NIB_W-1:0]  pos_next;
   logic [WORD_W-1:0] acc_base;
   logic [WORD_W-1:0] byte_shifted;
   logic [WORD_W-1:0] gathered;
   logic [WORD_W-1:0] sign_mask;
   entry_type         ent;

   // Stall only on a full queue, never on the result side directly
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // A first byte restarts in header phase
   assign ph       = req_first_byte ? PH_HEADER : phase_ff;
   assign pos_next = NIB_W'(pos_ff + 4'd1);

   // Place the byte at its little-endian position; bytes past eight drop out
   assign acc_base     = (ph == PH_LENGTH) ? len_acc_ff : off_acc_ff;
   assign byte_shifted = WORD_W'(req_data_byte) << {pos_ff[2:0], 3'b000};
   assign gathered     = (pos_ff < NIB_W'(MAX_BYTES)) ? (acc_base | byte_shifted)
                                                       : acc_base;

   // Sign fill above the last offset byte
   always_comb begin
      sign_mask = '0;
      if ((pos_next < NIB_W'(MAX_BYTES)) && ((req_data_byte & SIGN_BIT) != '0)) begin
         sign_mask = {WORD_W{1'b1}} << {pos_next[2:0], 3'b000};
      end
   end

   // Classify the byte and build the command
   always_comb begin
      phase_in    = phase_ff;
      len_left_in = len_left_ff;
      off_left_in = off_left_ff;
      pos_in      = pos_ff;
      len_acc_in  = len_acc_ff;
      off_acc_in  = off_acc_ff;

      ent           = '0;
      ent.restart   = req_first_byte;
      ent.start_vcn = req_start_vcn;
      ent.op        = OP_NONE;
      ent.status    = ST_RUN;
      ent.last      = req_last_byte;
      ent.length    = len_acc_ff;
      ent.offset    = off_acc_ff;

      if (accept) begin
         phase_in = ph;
         case (ph)
            PH_DONE: begin
               // idle byte, drop
            end
            PH_HEADER: begin
               if (req_data_byte == '0) begin
                  ent.op     = OP_STOP;
                  ent.status = ST_END;
                  ent.last   = 1'b1;
                  phase_in   = PH_DONE;
               end else if ((req_data_byte[3:0] & NIB_MASK) == '0) begin
                  ent.op     = OP_STOP;
                  ent.status = ST_ZERO_LEN;
                  ent.last   = 1'b1;
                  phase_in   = PH_DONE;
               end else begin
                  len_left_in = req_data_byte[3:0];
                  off_left_in = req_data_byte[7:4];
                  pos_in      = '0;
                  len_acc_in  = '0;
                  off_acc_in  = '0;
                  phase_in    = PH_LENGTH;
                  if (req_last_byte) begin
                     ent.op     = OP_STOP;
                     ent.status = ST_TRUNC;
                     phase_in   = PH_DONE;
                  end
               end
            end
            PH_LENGTH: begin
               len_acc_in  = gathered;
               pos_in      = pos_next;
               len_left_in = NIB_W'(len_left_ff - 4'd1);
               if (len_left_in != '0) begin
                  if (req_last_byte) begin
                     ent.op     = OP_STOP;
                     ent.status = ST_TRUNC;
                     phase_in   = PH_DONE;
                  end
               end else if (off_left_ff == '0) begin
                  ent.op     = OP_RUN;
                  ent.length = gathered;
                  ent.offset = off_acc_ff;
                  phase_in   = req_last_byte ? PH_DONE : PH_HEADER;
               end else begin
                  pos_in   = '0;
                  phase_in = PH_OFFSET;
                  if (req_last_byte) begin
                     ent.op     = OP_STOP;
                     ent.status = ST_TRUNC;
                     phase_in   = PH_DONE;
                  end
               end
            end
            PH_OFFSET: begin
               off_acc_in  = gathered;
               pos_in      = pos_next;
               off_left_in = NIB_W'(off_left_ff - 4'd1);
               if (off_left_in != '0) begin
                  if (req_last_byte) begin
                     ent.op     = OP_STOP;
                     ent.status = ST_TRUNC;
                     phase_in   = PH_DONE;
                  end
               end else begin
                  off_acc_in = gathered | sign_mask;
                  ent.op     = OP_RUN;
                  ent.length = len_acc_ff;
                  ent.offset = gathered | sign_mask;
                  phase_in   = req_last_byte ? PH_DONE : PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // Push a beat when it restarts the list or yields a result
   assign push.valid = accept && (req_first_byte || (ent.op != OP_NONE));
   assign push.entry = ent;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_DONE;
         len_left_ff <= '0;
         off_left_ff <= '0;
         pos_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         len_left_ff <= len_left_in;
         off_left_ff <= off_left_in;
         pos_ff      <= pos_in;
      end
   end

   // Accumulators
   always_ff @(posedge clock) begin
      len_acc_ff <= len_acc_in;
      off_acc_ff <= off_acc_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/rld_queue.sv */
`default_nettype none

module rld_queue
   import rld_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire beat_type push,
   output logic          full,
   output beat_type      head,
   input  wire logic     pop
);

   logic      v0_ff, v0_in;
   logic      v1_ff, v1_in;
   entry_type e0_ff, e0_in;
   entry_type e1_ff, e1_in;

   assign full       = v1_ff;
   assign head.valid = v0_ff;
   assign head.entry = e0_ff;

   // Advance on pop, then fill the first free slot
   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      if (pop) begin
         v0_in = v1_ff;
         e0_in = e1_ff;
         v1_in = 1'b0;
      end
      if (push.valid) begin
         if (!v0_in) begin
            v0_in = 1'b1;
            e0_in = push.entry;
         end else begin
            v1_in = 1'b1;
            e1_in = push.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/rld_back.sv */
`default_nettype none

module rld_back
   import rld_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire beat_type   head,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [WORD_W-1:0]   rsp_run_vcn,
   output logic [WORD_W-1:0]   rsp_run_lcn,
   output logic [WORD_W-1:0]   rsp_run_length,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_is_last
);

   logic [WORD_W-1:0]   cur_vcn_ff, cur_vcn_in;
   logic [WORD_W-1:0]   cur_lcn_ff, cur_lcn_in;
   logic                valid_ff, valid_in;
   logic [WORD_W-1:0]   vcn_ff, vcn_in;
   logic [WORD_W-1:0]   lcn_ff, lcn_in;
   logic [WORD_W-1:0]   len_ff, len_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic              out_free;
   logic [WORD_W-1:0] base_vcn;
   logic [WORD_W-1:0] base_lcn;
   logic [WORD_W-1:0] run_lcn;
   logic [WORD_W-1:0] next_vcn;

   // Take a command when the output register is empty or being drained
   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;

   // Restart loads the starting cluster and clears the logical position
   assign base_vcn = head.entry.restart ? head.entry.start_vcn : cur_vcn_ff;
   assign base_lcn = head.entry.restart ? '0 : cur_lcn_ff;
   assign run_lcn  = base_lcn + head.entry.offset;
   assign next_vcn = base_vcn + head.entry.length;

   always_comb begin
      cur_vcn_in = cur_vcn_ff;
      cur_lcn_in = cur_lcn_ff;
      valid_in   = valid_ff && rsp_stall;
      vcn_in     = vcn_ff;
      lcn_in     = lcn_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      if (pop) begin
         cur_vcn_in = base_vcn;
         cur_lcn_in = base_lcn;
         case (head.entry.op)
            OP_RUN: begin
               valid_in   = 1'b1;
               vcn_in     = base_vcn;
               lcn_in     = run_lcn;
               len_in     = head.entry.length;
               status_in  = ST_RUN;
               last_in    = head.entry.last;
               cur_vcn_in = next_vcn;
               cur_lcn_in = run_lcn;
            end
            OP_STOP: begin
               valid_in  = 1'b1;
               vcn_in    = base_vcn;
               lcn_in    = base_lcn;
               len_in    = '0;
               status_in = head.entry.status;
               last_in   = 1'b1;
            end
            default: begin
               // restart only, no result
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         cur_vcn_ff <= '0;
         cur_lcn_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         cur_vcn_ff <= cur_vcn_in;
         cur_lcn_ff <= cur_lcn_in;
      end
   end

   always_ff @(posedge clock) begin
      vcn_ff    <= vcn_in;
      lcn_ff    <= lcn_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_run_vcn    = vcn_ff;
   assign rsp_run_lcn    = lcn_ff;
   assign rsp_run_length = len_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_last    = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/rld_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module rld_checker
   import rld_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [BYTE_W-1:0]   req_data_byte,
   input wire logic                req_first_byte,
   input wire logic                req_last_byte,
   input wire logic [WORD_W-1:0]   req_start_vcn,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [WORD_W-1:0]   rsp_run_vcn,
   input wire logic [WORD_W-1:0]   rsp_run_lcn,
   input wire logic [WORD_W-1:0]   rsp_run_length,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_is_last
);

   // A stalled result beat holds
   `RLD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_run_vcn) && $stable(rsp_run_lcn) && $stable(rsp_status))

   // Any non-run status ends the list
   `RLD_ASSERT_IMP(a_stop_is_last, clock, reset, rsp_valid && (rsp_status != ST_RUN), rsp_is_last)

   // Non-run results carry no length
   `RLD_ASSERT_IMP(a_stop_no_length, clock, reset, rsp_valid && (rsp_status != ST_RUN), rsp_run_length == '0)

   // Nothing comes out right after reset
   `RLD_ASSERT_NXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

endmodule

bind run_list_decoder rld_checker u_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
   import rld_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 9;
   localparam int ITEM_TARGET    = 1350;
   localparam int QUIET_ITEMS    = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TIMEOUT_CYCLES = 400000;

   // One result beat as seen on the rsp channel
   typedef struct packed {
      logic [WORD_W-1:0] vcn;
      logic [WORD_W-1:0] lcn;
      logic [WORD_W-1:0] length;
      status_type        status;
      logic              last;
   } run_beat_type;

   // How a generated run list is closed off
   typedef enum {
      END_MARKER,
      END_AT_RUN,
      END_TRUNCATED,
      END_ZERO_NIBBLE,
      END_OPEN
   } list_end_type;

   // Decoder state mirror plus the queue of runs still owed by the block
   class run_list_scoreboard;
      phase_type         phase;
      logic [NIB_W-1:0]  len_left;
      logic [NIB_W-1:0]  off_left;
      logic [NIB_W-1:0]  pos;
      logic [WORD_W-1:0] len_acc;
      logic [WORD_W-1:0] off_acc;
      logic [WORD_W-1:0] cur_vcn;
      logic [WORD_W-1:0] cur_lcn;
      run_beat_type      expected_runs[$];
      int                failures;

      function new();
         phase    = PH_DONE;
         len_left = '0;
         off_left = '0;
         pos      = '0;
         len_acc  = '0;
         off_acc  = '0;
         cur_vcn  = '0;
         cur_lcn  = '0;
         failures = 0;
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction

      // Merge one little-endian byte; bytes past the eighth fall off
      function logic [WORD_W-1:0] gather(logic [WORD_W-1:0] acc, logic [BYTE_W-1:0] b);
         logic [WORD_W-1:0] merged;
         merged = acc;
         if (pos < MAX_BYTES)
            merged = merged | ({{(WORD_W-BYTE_W){1'b0}}, b} << (8 * pos));
         pos = pos + 1'b1;
         return merged;
      endfunction

      function void push_run(logic [WORD_W-1:0] vcn, logic [WORD_W-1:0] lcn,
                             logic [WORD_W-1:0] length, status_type st, logic last);
         run_beat_type r;
         r.vcn    = vcn;
         r.lcn    = lcn;
         r.length = length;
         r.status = st;
         r.last   = last;
         expected_runs.push_back(r);
      endfunction

      // End of list, bad header or truncation: report position and go idle
      function void close_list(status_type st);
         push_run(cur_vcn, cur_lcn, '0, st, 1'b1);
         phase = PH_DONE;
      endfunction

      function void finish_run(logic last);
         logic [WORD_W-1:0] lcn;
         lcn = cur_lcn + off_acc;
         push_run(cur_vcn, lcn, len_acc, ST_RUN, last);
         cur_vcn = cur_vcn + len_acc;
         cur_lcn = lcn;
         phase   = last ? PH_DONE : PH_HEADER;
      endfunction

      // Advance the mirror by one accepted input beat
      function void note_byte(logic [BYTE_W-1:0] b, logic first, logic last,
                              logic [WORD_W-1:0] svcn);
         if (first) begin
            cur_vcn = svcn;
            cur_lcn = '0;
            phase   = PH_HEADER;
         end
         case (phase)
            PH_DONE: ;
            PH_HEADER: begin
               if (b == '0)
                  close_list(ST_END);
               else if ((b[NIB_W-1:0] & NIB_MASK) == '0)
                  close_list(ST_ZERO_LEN);
               else begin
                  len_left = b[NIB_W-1:0];
                  off_left = b[BYTE_W-1:NIB_W];
                  pos      = '0;
                  len_acc  = '0;
                  off_acc  = '0;
                  phase    = PH_LENGTH;
                  if (last)
                     close_list(ST_TRUNC);
               end
            end
            PH_LENGTH: begin
               len_acc  = gather(len_acc, b);
               len_left = len_left - 1'b1;
               if (len_left != '0) begin
                  if (last)
                     close_list(ST_TRUNC);
               end else if (off_left == '0)
                  finish_run(last);
               else begin
                  pos   = '0;
                  phase = PH_OFFSET;
                  if (last)
                     close_list(ST_TRUNC);
               end
            end
            default: begin
               off_acc  = gather(off_acc, b);
               off_left = off_left - 1'b1;
               if (off_left != '0) begin
                  if (last)
                     close_list(ST_TRUNC);
               end else begin
                  // sign-extend a short negative delta from its top byte
                  if (pos < MAX_BYTES && (b & SIGN_BIT) != '0)
                     off_acc = off_acc | ({WORD_W{1'b1}} << (8 * pos));
                  finish_run(last);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want_v,
                                  logic [WORD_W-1:0] got_v);
         if (want_v !== got_v) begin
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
            failures++;
         end
      endfunction

      // Match one result beat against the oldest outstanding run
      function void check_run(run_beat_type got);
         run_beat_type want;
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected result beat vcn %h lcn %h length %h status %0d last %0b",
                     $time, got.vcn, got.lcn, got.length, got.status, got.last);
            failures++;
            return;
         end
         want = expected_runs.pop_front();
         compare_field("run_vcn", want.vcn, got.vcn);
         compare_field("run_lcn", want.lcn, got.lcn);
         compare_field("run_length", want.length, got.length);
         compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
         compare_field("is_last", WORD_W'(want.last), WORD_W'(got.last));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                req_first_byte;
   logic                req_last_byte;
   logic [WORD_W-1:0]   req_start_vcn;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [WORD_W-1:0]   rsp_run_vcn;
   logic [WORD_W-1:0]   rsp_run_lcn;
   logic [WORD_W-1:0]   rsp_run_length;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_is_last;

   run_list_scoreboard sb = new();
   run_beat_type       seen_run;
   int                 n_items = 0;
   bit                 quiet = 1'b0;
   bit                 hold_rsp = 1'b0;

   run_list_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_start_vcn  (req_start_vcn),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_vcn    (rsp_run_vcn),
      .rsp_run_lcn    (rsp_run_lcn),
      .rsp_run_length (rsp_run_length),
      .rsp_status     (rsp_status),
      .rsp_is_last    (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("tb_top NOT OK");
      $finish;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_byte(req_data_byte, req_first_byte, req_last_byte, req_start_vcn);
         if (rsp_valid && !rsp_stall) begin
            seen_run.vcn    = rsp_run_vcn;
            seen_run.lcn    = rsp_run_lcn;
            seen_run.length = rsp_run_length;
            seen_run.status = status_type'(rsp_status);
            seen_run.last   = rsp_is_last;
            sb.check_run(seen_run);
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Field bytes lean toward sign and all-zero / all-one patterns
   function automatic logic [BYTE_W-1:0] pick_field_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_start_vcn();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2:       return {WORD_W{1'b1}} - WORD_W'($urandom_range(0, 4095));
         default: return rand_word();
      endcase
   endfunction

   // Mostly well-formed endings; truncated and open lists are the minority
   function automatic list_end_type pick_ending();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return END_MARKER;
         4, 5:       return END_AT_RUN;
         6:          return END_ZERO_NIBBLE;
         7, 8:       return END_TRUNCATED;
         default:    return END_OPEN;
      endcase
   endfunction

   // Offer one beat, with an optional idle burst ahead of it, and hold until taken
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first,
                            input logic last, input logic [WORD_W-1:0] svcn);
      int gap;
      @(negedge clock);
      if (!quiet && !hold_rsp && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_first_byte <= first;
      req_last_byte  <= last;
      req_start_vcn  <= svcn;
      do @(posedge clock); while (req_stall);
      n_items++;
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_all_results();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Build a list of runs with random content and close it as asked
   task automatic send_list(input int n_runs, input list_end_type how,
                            input int max_len, input int max_off);
      logic [BYTE_W-1:0] seq[$];
      logic [WORD_W-1:0] svcn;
      logic              mark_last;
      int                l;
      int                o;
      int                r;
      int                i;
      int                cut;
      for (r = 0; r < n_runs; r++) begin
         l = $urandom_range(1, max_len);
         o = $urandom_range(0, max_off);
         seq.push_back({o[NIB_W-1:0], l[NIB_W-1:0]});
         for (i = 0; i < l; i++) seq.push_back(pick_field_byte());
         for (i = 0; i < o; i++) seq.push_back(pick_field_byte());
      end
      mark_last = 1'b0;
      case (how)
         END_MARKER:      seq.push_back(8'h00);
         END_ZERO_NIBBLE: seq.push_back({NIB_W'($urandom_range(1, 15)), 4'h0});
         END_AT_RUN:      mark_last = 1'b1;
         default: begin
            // cut anywhere; an open list is dropped by the next restart
            cut = $urandom_range(0, seq.size() - 1);
            seq = seq[0:cut];
            mark_last = (how == END_TRUNCATED);
         end
      endcase
      svcn = pick_start_vcn();
      for (i = 0; i < seq.size(); i++)
         send_byte(seq[i], i == 0, mark_last && i == seq.size() - 1,
                   i == 0 ? svcn : rand_word());
   endtask

   initial begin
      bit held;
      bit paused;
      bit wide;
      held           = 1'b0;
      paused         = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_first_byte = 1'b0;
      req_last_byte  = 1'b0;
      req_start_vcn  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray byte while idle is dropped
      send_byte(8'h5A, 1'b0, 1'b1, '1);
      // end marker and bad header right at the start of a list
      send_byte(8'h00, 1'b1, 1'b0, '1);
      send_byte(8'hF0, 1'b1, 1'b0, '0);
      // zero-length sparse run, negative delta, positive two-byte delta, end
      send_byte(8'h01, 1'b1, 1'b0, '1);
      send_byte(8'h00, 1'b0, 1'b0, '0);
      send_byte(8'h11, 1'b0, 1'b0, '0);
      send_byte(8'hFF, 1'b0, 1'b0, '1);
      send_byte(8'h80, 1'b0, 1'b0, '0);
      send_byte(8'h21, 1'b0, 1'b0, '1);
      send_byte(8'h01, 1'b0, 1'b0, '0);
      send_byte(8'hFF, 1'b0, 1'b0, '1);
      send_byte(8'h7F, 1'b0, 1'b0, '0);
      send_byte(8'h00, 1'b0, 1'b0, '1);
      // list cut off at its header
      send_byte(8'h11, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
      // list ends exactly at a run boundary
      send_byte(8'h01, 1'b1, 1'b0, 64'h8000_0000_0000_0000);
      send_byte(8'h05, 1'b0, 1'b1, '0);
      // restart in the middle of a run
      send_byte(8'h22, 1'b1, 1'b0, 64'h10);
      send_byte(8'h10, 1'b0, 1'b0, '0);
      send_byte(8'h00, 1'b1, 1'b0, 64'h20);
      // truncated inside the offset field
      send_byte(8'h21, 1'b1, 1'b0, 64'h30);
      send_byte(8'h01, 1'b0, 1'b0, '0);
      send_byte(8'hFF, 1'b0, 1'b1, '0);

      while (n_items < ITEM_TARGET) begin
         if (n_items >= ITEM_TARGET - QUIET_ITEMS)
            quiet = 1'b1;
         if (!held && n_items >= 400) begin
            // short runs back to back while the result side holds off
            held     = 1'b1;
            hold_rsp = 1'b1;
            send_list(20, END_MARKER, 1, 0);
         end else if (!paused && n_items >= 800) begin
            paused = 1'b1;
            idle_sender();
            wait_all_results();
         end else if ($urandom_range(0, 6) == 0) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, rand_word());
         end else begin
            wide = ($urandom_range(0, 9) == 0);
            send_list($urandom_range(1, 6), pick_ending(), wide ? 15 : 3, wide ? 15 : 4);
         end
      end

      idle_sender();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/rld_pkg.sv
hw/rtl/rld_front.sv
hw/rtl/rld_queue.sv
hw/rtl/rld_back.sv
hw/rtl/run_list_decoder.sv
hw/rtl/rld_checker.sv
test/tb_top.sv
